### hdl/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg: shared constants for the partitioned Bloom filter
// Sizes of the hash bank and the bit store, and the mixing constant.
// ----------------------------------------------------------------------------
package pbf_pkg;
	localparam int NUM_HASHES = 17;
	localparam int PART_BITS = 4096;
	localparam logic [31:0] MIX_M = 32'h5bd1e995;

	// bit store is kept in rows of up to 32 bits
	localparam int ROW_W = (PART_BITS < 32) ? PART_BITS : 32;
	localparam int LO_W = $clog2(ROW_W);
	localparam int POS_W = $clog2(PART_BITS);
	localparam int ROWS_PP = PART_BITS / ROW_W;
	localparam int DEPTH = NUM_HASHES * ROWS_PP;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

	typedef logic [ROW_W-1:0] row_t;
endpackage

### hdl/pbf_ram.sv
// ----------------------------------------------------------------------------
// pbf_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/partitioned_bloom_filter_murmur2_unit.sv
// A key word is mixed into each hash state in turn, a full word first going
// through the K1-K3 multiply steps; the last word then probes one bit per
// partition, then the result registers. The unit takes one word at a time,
// held back by the shared 32-bit multiplier and the single read-modify-write
// port of the bit store. Reset: a clearing pass zeroes the bit store; no
// request is taken until it ends.
// ----------------------------------------------------------------------------
// partitioned_bloom_filter_murmur2_unit: Bloom filter over MurmurHash2
// Mixes key words into a bank of hash states with one shared multiplier,
// then probes one bit per partition to add or search the key.
// ----------------------------------------------------------------------------
module partitioned_bloom_filter_murmur2_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	input  logic [15:0] key_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic        done_action
);
	import pbf_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_K1    = 4'd2;
	localparam logic [3:0] ST_K2    = 4'd3;
	localparam logic [3:0] ST_K3    = 4'd4;
	localparam logic [3:0] ST_MA    = 4'd5;
	localparam logic [3:0] ST_MB    = 4'd6;
	localparam logic [3:0] ST_FA    = 4'd7;
	localparam logic [3:0] ST_FB    = 4'd8;
	localparam logic [3:0] ST_FC    = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	logic [3:0]       state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [IDX_W-1:0] idx_q;
	logic             in_key_q;
	logic             all_q;
	logic [31:0]      word_q;
	logic [2:0]       cnt_q;
	logic             last_q;
	logic             action_q;
	logic [15:0]      len_q;
	logic [31:0]      mul_q;
	logic [31:0]      k_q;
	logic [31:0]      hs_q [NUM_HASHES];
	logic [ADDR_W-1:0] row_q;
	logic [LO_W-1:0]  lo_q;
	logic             out_valid_q;
	logic             found_q;
	logic             done_action_q;

	logic [31:0]      mul_a;
	logic [31:0]      prod;
	logic [31:0]      src;
	logic [31:0]      tail;
	logic [31:0]      fin;
	logic [ADDR_W-1:0] row_d;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	row_t             ram_wdata;
	row_t             ram_rdata;
	logic             last_idx;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign found = found_q;
	assign done_action = done_action_q;
	assign last_idx = (idx_q == IDX_W'(NUM_HASHES - 1));

	// current state: seed xor length on the first word of a key
	assign src = in_key_q ? hs_q[idx_q] : ((32'(idx_q) + 32'd1) ^ {16'd0, len_q});

	// tail bytes below byte count
	always_comb begin
		case (cnt_q)
			3'd1:    tail = {24'd0, word_q[7:0]};
			3'd2:    tail = {16'd0, word_q[15:0]};
			3'd3:    tail = {8'd0, word_q[23:0]};
			default: tail = word_q;
		endcase
	end

	// select the shared multiplier operand
	always_comb begin
		unique case (state_q)
			ST_K1:   mul_a = word_q;
			ST_K2:   mul_a = mul_q ^ (mul_q >> 24);
			ST_MA:   mul_a = (cnt_q == 3'd4) ? src : (src ^ tail);
			ST_FA:   mul_a = hs_q[idx_q] ^ (hs_q[idx_q] >> 13);
			default: mul_a = 32'd0;
		endcase
	end

	assign prod = mul_a * MIX_M;
	assign fin = mul_q ^ (mul_q >> 15);
	assign row_d = ADDR_W'(ADDR_W'(idx_q) * ADDR_W'(ROWS_PP))
		+ ADDR_W'(fin[POS_W-1:0] >> LO_W);

	// bit store write: clearing pass or probe set
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = row_q;
		ram_wdata = ram_rdata | (row_t'(1) << lo_q);
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_FC && !action_q) begin
			ram_we = 1'b1;
		end
	end

	pbf_ram #(
		.WIDTH(ROW_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(row_d),
		.rdata(ram_rdata)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= data_word;
			cnt_q <= (byte_count > 3'd4) ? 3'd4 : byte_count;
			last_q <= last;
			action_q <= action;
			if (!in_key_q) begin
				len_q <= key_len;
			end
		end
		mul_q <= prod;
		if (state_q == ST_K3) begin
			k_q <= mul_q;
		end
		if (state_q == ST_MB) begin
			if (cnt_q == 3'd4) begin
				hs_q[idx_q] <= mul_q ^ k_q;
			end else if (cnt_q != 3'd0) begin
				hs_q[idx_q] <= mul_q;
			end else begin
				hs_q[idx_q] <= src;
			end
		end
		if (state_q == ST_FB) begin
			row_q <= row_d;
			lo_q <= fin[LO_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			idx_q <= '0;
			in_key_q <= 1'b0;
			all_q <= 1'b1;
			out_valid_q <= 1'b0;
			found_q <= 1'b0;
			done_action_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q <= '0;
					if (in_valid) begin
						state_q <= (byte_count >= 3'd4) ? ST_K1 : ST_MA;
					end
				end
				ST_K1: state_q <= ST_K2;
				ST_K2: state_q <= ST_K3;
				ST_K3: state_q <= ST_MA;
				ST_MA: state_q <= ST_MB;
				ST_MB: begin
					if (!last_idx) begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_MA;
					end else begin
						idx_q <= '0;
						in_key_q <= 1'b1;
						all_q <= 1'b1;
						state_q <= last_q ? ST_FA : ST_IDLE;
					end
				end
				ST_FA: state_q <= ST_FB;
				ST_FB: state_q <= ST_FC;
				ST_FC: begin
					if (action_q && !ram_rdata[lo_q]) begin
						all_q <= 1'b0;
					end
					if (!last_idx) begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_FA;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the result register is free
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						found_q <= action_q & all_q;
						done_action_q <= action_q;
						in_key_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### hdl/pbf_checker.sv
// ----------------------------------------------------------------------------
// pbf_checker: port-level checks for the Bloom filter unit
// Watches the handshakes and the result fields over time.
// ----------------------------------------------------------------------------
module pbf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input logic done_action
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// an add never reports found
	a_add_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> done_action)
		else $error("found set on an add");

	// busy right after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a request");

	// no new result in the cycle after one is taken
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result repeated");
endmodule

bind partitioned_bloom_filter_murmur2_unit pbf_checker u_pbf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.found(found),
	.done_action(done_action)
);
